@@ rtl/tfr_pkg.sv @@
`timescale 1ns / 1ps

package tfr_pkg;

    // ring geometry
    localparam int BUF_BYTES = 1024;
    localparam int IDX_W     = $clog2(BUF_BYTES);
    localparam int CAP_W     = IDX_W + 1;
    localparam int USED_W    = CAP_W + 1;
    localparam int WB_DEPTH  = 4;
    localparam int WB_CNT_W  = $clog2(WB_DEPTH + 1);

    // opcodes
    localparam logic [2:0] OP_BEGIN = 3'd0;
    localparam logic [2:0] OP_ESC   = 3'd1;
    localparam logic [2:0] OP_RAW   = 3'd2;
    localparam logic [2:0] OP_END   = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_RING_BYTES  = 2'd0;
    localparam logic [1:0] CFG_FRAME_BYTE  = 2'd1;
    localparam logic [1:0] CFG_ESCAPE_BYTE = 2'd2;
    localparam logic [1:0] CFG_ESCAPE_XOR  = 2'd3;

    // configuration reset values
    localparam logic [CAP_W-1:0] RST_RING_BYTES  = CAP_W'(BUF_BYTES);
    localparam logic [7:0]       RST_FRAME_BYTE  = 8'd126;
    localparam logic [7:0]       RST_ESCAPE_BYTE = 8'd125;
    localparam logic [7:0]       RST_ESCAPE_XOR  = 8'd32;

    typedef struct packed {
        logic [7:0]        read_byte;
        logic              empty_res;
        logic [USED_W-1:0] used_count;
        logic              overrun;
    } t_result;

    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_stuff;

    function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx,
                                                    input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] n;
        n = {1'b0, idx} + CAP_W'(1);
        if (n >= cap) begin
            n = '0;
        end
        return n[IDX_W-1:0];
    endfunction

    function automatic t_stuff stuff_byte(input logic [7:0] b, input logic [7:0] frame,
                                          input logic [7:0] esc, input logic [7:0] xv);
        t_stuff s;
        if (b == frame || b == esc) begin
            s.two = 1'b1;
            s.b0  = esc;
            s.b1  = b ^ xv;
        end else begin
            s.two = 1'b0;
            s.b0  = b;
            s.b1  = b;
        end
        return s;
    endfunction

endpackage

@@ rtl/trace_record_framer_ring.sv @@
`timescale 1ns / 1ps
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+-------------------------------------
// input     | in        | i_in_valid / o_in_stall    | i_opcode, i_data_byte
// result    | out       | o_out_valid / i_out_stall  | o_read_byte, o_empty_res,
//           |           |                            | o_used_count, o_overrun
// config    | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// a record item holds the single-port ring memory while its bytes (1 to 4) are written and the
// next is taken as its last byte is written: begin 2-4 bytes, end 2-3, escaped 1-2, raw 1
// a read waits until the write buffer is empty, then reads the ring memory
// each result passes through the result stage, then a two-entry result queue
// reset is synchronous and active low; no clearing pass, ring entries are unwritten
// a stalled result side stops input transfers once the result stage and queue hold two results

module trace_record_framer_ring
    import tfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input items
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_opcode,
    input  logic [7:0]        i_data_byte,
    // results
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_read_byte,
    output logic              o_empty_res,
    output logic [USED_W-1:0] o_used_count,
    output logic              o_overrun,
    // configuration writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [CAP_W-1:0]  i_cfg_data
);

    // configuration
    logic [CAP_W-1:0]  r_ring_bytes;
    logic [7:0]        r_frame;
    logic [7:0]        r_esc;
    logic [7:0]        r_xor;

    // architectural state, updated at transfer time
    logic [IDX_W-1:0]  r_head, n_head;
    logic [IDX_W-1:0]  r_tail, n_tail;
    logic [USED_W-1:0] r_used, n_used;
    logic [7:0]        r_seq, n_seq;
    logic [7:0]        r_cs, n_cs;

    // write buffer draining into the ring, one byte a cycle
    logic [7:0]          r_wb [WB_DEPTH];
    logic [WB_CNT_W-1:0] r_wb_cnt;
    logic [IDX_W-1:0]    r_wr_addr;

    // result stage and result queue
    logic    r_s1_valid;
    logic    r_s1_from_mem;
    t_result r_s1_res, n_s1_res;
    logic    n_s1_from_mem;
    t_result r_fifo [2];
    logic    r_fifo_wp;
    logic    r_fifo_rp;
    logic [1:0] r_fifo_cnt;

    // combinational
    logic [CAP_W-1:0]  cap;
    logic [USED_W-1:0] lim;
    logic [7:0]        seq_inc;
    logic [7:0]        a_in;
    logic              a_stf;
    logic              has_b;
    logic [7:0]        b_in;
    logic              b_stf;
    t_stuff            sa;
    t_stuff            sb;
    logic              a_two;
    logic              b_two;
    logic [7:0]        a_b1;
    logic [7:0]        b_b0;
    logic [7:0]        b_b1;
    logic [7:0]        cs_new;
    logic [7:0]        wl [WB_DEPTH];
    logic [WB_CNT_W-1:0] wl_cnt;
    logic [IDX_W-1:0]  h_chain [WB_DEPTH+1];
    logic [IDX_W-1:0]  head_after;
    logic [USED_W:0]   used_sum;
    logic [USED_W-1:0] used_after;
    logic              end_ovr;
    logic              is_write;
    logic              is_read;
    logic              port_ok;
    logic [1:0]        occ;
    logic              pop;
    logic              space;
    logic              accept;
    logic              mem_we;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_addr;
    logic [7:0]        mem_q;
    t_result           push_res;
    t_result           out_res;

    assign o_cfg_ready = 1'b1;

    // ring size clamped to at least 2 and at most what storage holds
    always_comb begin
        if (r_ring_bytes < CAP_W'(2)) begin
            cap = CAP_W'(2);
        end else if (r_ring_bytes > CAP_W'(BUF_BYTES)) begin
            cap = CAP_W'(BUF_BYTES);
        end else begin
            cap = r_ring_bytes;
        end
        lim = {cap, 1'b0};
    end

    // byte list of one record item: part a (maybe stuffed), then optional part b
    always_comb begin
        seq_inc = r_seq + 8'd1;
        a_in    = i_data_byte;
        a_stf   = 1'b0;
        has_b   = 1'b0;
        b_in    = i_data_byte;
        b_stf   = 1'b0;
        case (i_opcode)
            OP_BEGIN: begin
                a_in  = seq_inc;
                a_stf = 1'b1;
                has_b = 1'b1;
                b_stf = 1'b1;
            end
            OP_ESC: begin
                a_stf = 1'b1;
            end
            OP_END: begin
                a_in  = ~r_cs;
                a_stf = 1'b1;
                has_b = 1'b1;
                b_in  = r_frame;
            end
            default: begin
            end
        endcase

        sa    = stuff_byte(a_in, r_frame, r_esc, r_xor);
        sb    = stuff_byte(b_in, r_frame, r_esc, r_xor);
        a_two = a_stf && sa.two;
        b_two = b_stf && sb.two;
        a_b1  = a_two ? sa.b1 : a_in;
        b_b0  = b_two ? sb.b0 : b_in;
        b_b1  = b_two ? sb.b1 : b_in;

        // checksum after the item; end keeps the stored checksum byte
        case (i_opcode)
            OP_BEGIN: cs_new = seq_inc + i_data_byte;
            OP_END:   cs_new = a_b1;
            default:  cs_new = r_cs + i_data_byte;
        endcase

        wl[0] = a_two ? sa.b0 : a_in;
        if (a_two) begin
            wl[1] = a_b1;
            wl[2] = b_b0;
            wl[3] = b_b1;
        end else begin
            wl[1] = b_b0;
            wl[2] = b_b1;
            wl[3] = b_b1;
        end
        wl_cnt = WB_CNT_W'(1) + WB_CNT_W'(a_two)
               + (has_b ? (WB_CNT_W'(1) + WB_CNT_W'(b_two)) : WB_CNT_W'(0));
    end

    // head, used count and overrun after the stored bytes
    always_comb begin
        h_chain[0] = r_head;
        for (int i = 0; i < WB_DEPTH; i++) begin
            h_chain[i+1] = next_index(h_chain[i], cap);
        end
        head_after = h_chain[wl_cnt];

        used_sum = {1'b0, r_used} + (USED_W+1)'(wl_cnt);
        if (r_used >= lim) begin
            used_after = r_used;
        end else if (used_sum > {1'b0, lim}) begin
            used_after = lim;
        end else begin
            used_after = used_sum[USED_W-1:0];
        end
        end_ovr = (used_after > USED_W'(cap));
    end

    // transfer control
    always_comb begin
        is_write = (i_opcode == OP_BEGIN) || (i_opcode == OP_ESC)
                || (i_opcode == OP_RAW) || (i_opcode == OP_END);
        is_read  = (i_opcode == OP_READ);
        if (is_write) begin
            port_ok = (r_wb_cnt <= WB_CNT_W'(1));
        end else if (is_read) begin
            port_ok = (r_wb_cnt == '0);
        end else begin
            port_ok = 1'b1;
        end
        pop    = o_out_valid && !i_out_stall;
        occ    = r_fifo_cnt + 2'(r_s1_valid);
        space  = (occ <= 2'd1) || (occ == 2'd2 && pop);
        accept = i_in_valid && space && port_ok;
    end

    assign o_in_stall = !(space && port_ok);

    // next architectural state and the item's result
    always_comb begin
        n_head        = r_head;
        n_tail        = r_tail;
        n_used        = r_used;
        n_seq         = r_seq;
        n_cs          = r_cs;
        n_s1_res      = '0;
        n_s1_from_mem = 1'b0;
        mem_re        = 1'b0;
        n_s1_res.used_count = r_used;
        if (accept) begin
            if (is_write) begin
                n_head = head_after;
                n_used = used_after;
                n_cs   = cs_new;
                if (i_opcode == OP_BEGIN) begin
                    n_seq = seq_inc;
                end
                if (i_opcode == OP_END && end_ovr) begin
                    n_tail = head_after;
                    n_used = USED_W'(cap);
                    n_s1_res.overrun = 1'b1;
                end
                n_s1_res.used_count = n_used;
            end else if (is_read) begin
                if (r_used == '0) begin
                    n_s1_res.empty_res = 1'b1;
                end else begin
                    n_tail        = next_index(r_tail, cap);
                    n_used        = r_used - USED_W'(1);
                    n_s1_from_mem = 1'b1;
                    mem_re        = 1'b1;
                end
                n_s1_res.used_count = n_used;
            end
        end
    end

    // ring port: write buffer drain has the port, reads only run when it is empty
    assign mem_we   = (r_wb_cnt != '0);
    assign mem_addr = mem_we ? r_wr_addr : r_tail;

    tfr_ring_ram #(
        .DEPTH (BUF_BYTES),
        .WIDTH (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (r_wb[0]),
        .o_rdata (mem_q)
    );

    // read data joins its result in the cycle after the transfer
    always_comb begin
        push_res = r_s1_res;
        if (r_s1_from_mem) begin
            push_res.read_byte = mem_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_bytes <= RST_RING_BYTES;
            r_frame      <= RST_FRAME_BYTE;
            r_esc        <= RST_ESCAPE_BYTE;
            r_xor        <= RST_ESCAPE_XOR;
            r_head       <= '0;
            r_tail       <= '0;
            r_used       <= '0;
            r_seq        <= '0;
            r_cs         <= '0;
            r_wb_cnt     <= '0;
            r_s1_valid   <= 1'b0;
            r_fifo_wp    <= 1'b0;
            r_fifo_rp    <= 1'b0;
            r_fifo_cnt   <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RING_BYTES:  r_ring_bytes <= i_cfg_data;
                    CFG_FRAME_BYTE:  r_frame      <= i_cfg_data[7:0];
                    CFG_ESCAPE_BYTE: r_esc        <= i_cfg_data[7:0];
                    CFG_ESCAPE_XOR:  r_xor        <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            r_head <= n_head;
            r_tail <= n_tail;
            r_used <= n_used;
            r_seq  <= n_seq;
            r_cs   <= n_cs;

            // load a new byte list, or drain one byte
            if (accept && is_write) begin
                r_wb_cnt <= wl_cnt;
            end else if (mem_we) begin
                r_wb_cnt <= r_wb_cnt - WB_CNT_W'(1);
            end

            r_s1_valid <= accept;
            if (r_s1_valid) begin
                r_fifo_wp <= ~r_fifo_wp;
            end
            if (pop) begin
                r_fifo_rp <= ~r_fifo_rp;
            end
            r_fifo_cnt <= r_fifo_cnt + 2'(r_s1_valid) - 2'(pop);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept && is_write) begin
            for (int i = 0; i < WB_DEPTH; i++) begin
                r_wb[i] <= wl[i];
            end
            r_wr_addr <= r_head;
        end else if (mem_we) begin
            for (int i = 0; i < WB_DEPTH - 1; i++) begin
                r_wb[i] <= r_wb[i+1];
            end
            r_wr_addr <= next_index(r_wr_addr, cap);
        end
        if (accept) begin
            r_s1_res      <= n_s1_res;
            r_s1_from_mem <= n_s1_from_mem;
        end
        if (r_s1_valid) begin
            r_fifo[r_fifo_wp] <= push_res;
        end
    end

    assign out_res      = r_fifo[r_fifo_rp];
    assign o_out_valid  = (r_fifo_cnt != '0);
    assign o_read_byte  = out_res.read_byte;
    assign o_empty_res  = out_res.empty_res;
    assign o_used_count = out_res.used_count;
    assign o_overrun    = out_res.overrun;

endmodule

@@ rtl/tfr_ring_ram.sv @@
`timescale 1ns / 1ps

module tfr_ring_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/tfr_checker.sv @@
`timescale 1ns / 1ps

module tfr_checker
    import tfr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic [2:0]        i_opcode,
    input logic [7:0]        i_data_byte,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [7:0]        o_read_byte,
    input logic              o_empty_res,
    input logic [USED_W-1:0] o_used_count,
    input logic              o_overrun,
    input logic              i_cfg_valid,
    input logic              o_cfg_ready,
    input logic [1:0]        i_cfg_index,
    input logic [CAP_W-1:0]  i_cfg_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_byte)
            && $stable(o_empty_res) && $stable(o_used_count) && $stable(o_overrun))
        else $error("result changed while stalled");

    // an empty read leaves nothing held and pops no byte
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_empty_res |-> o_used_count == '0 && o_read_byte == 8'd0
            && !o_overrun)
        else $error("empty read with data");

    // an overrun trims the ring down to at most its storage
    a_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overrun |-> o_used_count <= USED_W'(BUF_BYTES) && !o_empty_res)
        else $error("overrun left too many bytes");

    // used count never passes twice the storage
    a_used_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_used_count <= USED_W'(2 * BUF_BYTES))
        else $error("used count out of range");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result after reset");

endmodule

bind trace_record_framer_ring tfr_checker u_tfr_checker (.*);
